// ----- rtl/cokf_pkg.sv -----
// cokf_pkg: shared types and constants for the clock offset kalman filter
// no dependencies
package cokf_pkg;

	localparam int FracBits = 40;
	localparam int WordBits = 64;
	localparam int RateBits = 41;
	localparam logic [RateBits-1:0] OffsetRateReset = 41'd10995116278;
	localparam logic [RateBits-1:0] DriftRateReset = 41'd1099511628;
	localparam logic [63:0] EpsQ64 = 64'd1844674407;

	localparam logic CfgOffsetRate = 1'b0;
	localparam logic CfgDriftRate = 1'b1;

	// input word modes
	localparam logic ModePredict = 1'b0;
	localparam logic ModeUpdate = 1'b1;

	// datapath micro operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PRED_OFF,
		OP_PRED_OO,
		OP_PRED_DD,
		OP_UPD_PRE,
		OP_DIV_K1,
		OP_DIV_K2,
		OP_UPD_OFF,
		OP_UPD_DRIFT,
		OP_UPD_OM,
		OP_UPD_OO,
		OP_UPD_OD,
		OP_UPD_DO,
		OP_UPD_DD
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t  op;
		logic clr_sat;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_ok;
	} status_t;

endpackage

// ----- rtl/cokf_mul.sv -----
// cokf_mul: sequential signed fixed point multiplier, 16 bits of b per cycle
// depends on cokf_pkg
module cokf_mul #(
	parameter int FRAC_BITS = cokf_pkg::FracBits,
	parameter int WORD_BITS = cokf_pkg::WordBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] p,
	output logic                        sat
);
	import cokf_pkg::*;

	localparam int Chunk = 16;
	localparam int Steps = (WORD_BITS + Chunk - 1) / Chunk;
	localparam int PW = 2 * WORD_BITS + 1;
	localparam int CW = $clog2(Steps + 1);

	logic [WORD_BITS-1:0] x_q, y_q;
	logic [PW-1:0]        acc_q;
	logic                 neg_q, busy_q, fin_q;
	logic [CW-1:0]        cnt_q;
	logic [Chunk-1:0]     ych;
	logic [PW-1:0]        part, rnd, sh;
	logic [WORD_BITS:0]   lim;

	// one partial product per cycle, chunk taken from the low end of y
	assign ych = y_q[Chunk-1:0];
	assign part = PW'(x_q) * PW'(ych);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(Steps - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= a[WORD_BITS-1] ? WORD_BITS'(-a) : a;
			y_q <= b[WORD_BITS-1] ? WORD_BITS'(-b) : b;
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (part << (Chunk * int'(cnt_q)));
			y_q <= y_q >> Chunk;
		end
	end

	// round half away from zero, then saturate magnitude
	assign rnd = acc_q + (PW'(1) << (FRAC_BITS - 1));
	assign sh = rnd >> FRAC_BITS;
	assign lim = {1'b0, {(WORD_BITS-1){1'b1}}} + (WORD_BITS+1)'(neg_q);

	always_comb begin
		sat = 1'b0;
		if (sh > PW'(lim)) begin
			sat = 1'b1;
			p = neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else if (neg_q) begin
			p = WORD_BITS'(-sh[WORD_BITS-1:0]);
		end else begin
			p = sh[WORD_BITS-1:0];
		end
	end
	assign done = fin_q;
endmodule

// ----- rtl/cokf_div.sv -----
// cokf_div: restoring divider for (a << FRAC_BITS) / d, one quotient bit per cycle
// depends on cokf_pkg
module cokf_div #(
	parameter int FRAC_BITS = cokf_pkg::FracBits,
	parameter int WORD_BITS = cokf_pkg::WordBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] d,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] q,
	output logic                        sat
);
	import cokf_pkg::*;

	localparam int NW = WORD_BITS + FRAC_BITS + 1;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]        num_q, quo_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS-1:0] d_q, x;
	logic                 neg_q, busy_q, fin_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS:0]   lim;

	assign x = a[WORD_BITS-1] ? WORD_BITS'(-a) : a;
	assign trial = {rem_q, num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// numerator is the magnitude shifted up plus half the divisor for rounding
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (NW'(x) << FRAC_BITS) + NW'(d[WORD_BITS-1:1]);
			d_q <= d;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a[WORD_BITS-1];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= WORD_BITS'(trial - {1'b0, d_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[WORD_BITS-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign lim = {1'b0, {(WORD_BITS-1){1'b1}}} + (WORD_BITS+1)'(neg_q);

	always_comb begin
		sat = 1'b0;
		if (quo_q > NW'(lim)) begin
			sat = 1'b1;
			q = neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else if (neg_q) begin
			q = WORD_BITS'(-quo_q[WORD_BITS-1:0]);
		end else begin
			q = quo_q[WORD_BITS-1:0];
		end
	end
	assign done = fin_q;
endmodule

// ----- rtl/cokf_datapath.sv -----
// cokf_datapath: filter state, saturating add and subtract, shared multiplier and divider
// depends on cokf_pkg, cokf_mul, cokf_div
module cokf_datapath #(
	parameter int FRAC_BITS = cokf_pkg::FracBits,
	parameter int WORD_BITS = cokf_pkg::WordBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cokf_pkg::cmd_t              cmd,
	output cokf_pkg::status_t           status,
	input  logic [62:0]                 time_step,
	input  logic [63:0]                 meas_offset,
	input  logic [62:0]                 meas_variance,
	input  logic [cokf_pkg::RateBits-1:0] offset_var_rate,
	input  logic [cokf_pkg::RateBits-1:0] drift_var_rate,
	output logic signed [WORD_BITS-1:0] offset_estimate,
	output logic signed [WORD_BITS-1:0] drift_estimate,
	output logic signed [WORD_BITS-1:0] offset_variance,
	output logic                        saturated
);
	import cokf_pkg::*;

	localparam logic signed [WORD_BITS-1:0] WMax = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMin = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] One = WORD_BITS'(1) << FRAC_BITS;
	localparam logic signed [WORD_BITS-1:0] Eps =
		WORD_BITS'((EpsQ64 + (64'd1 << (63 - FRAC_BITS))) >> (64 - FRAC_BITS));

	logic signed [WORD_BITS-1:0] off_q, drf_q, oo_q, od_q, do_q, dd_q;
	logic signed [WORD_BITS-1:0] dt_q, z_q, r_q, innov_q, s_q, k1_q, k2_q;
	logic                        sat_q, sok_q;
	logic signed [WORD_BITS-1:0] res_off_q, res_drf_q, res_oo_q;
	logic                        res_sat_q;

	// operand selection for the shared units
	logic signed [WORD_BITS-1:0] ma, mb, da;
	logic                        mstart, dstart, mdone, ddone, msat, dsat;
	logic signed [WORD_BITS-1:0] mp, dq;
	logic                        mbusy_q, dbusy_q;

	// input clipping to the word range
	function automatic logic signed [WORD_BITS-1:0] clipu(input logic [62:0] v);
		if (65'(v) > 65'(WMax)) return WMax;
		return WORD_BITS'(v);
	endfunction
	function automatic logic clipu_s(input logic [62:0] v);
		return 65'(v) > 65'(WMax);
	endfunction
	function automatic logic signed [WORD_BITS-1:0] clips(input logic signed [63:0] v);
		if (65'(signed'(v)) > 65'(signed'(WMax))) return WMax;
		if (65'(signed'(v)) < 65'(signed'(WMin))) return WMin;
		return WORD_BITS'(v);
	endfunction
	function automatic logic clips_s(input logic signed [63:0] v);
		return (65'(signed'(v)) > 65'(signed'(WMax))) || (65'(signed'(v)) < 65'(signed'(WMin)));
	endfunction

	// saturating add with overflow flag in msb
	function automatic logic [WORD_BITS:0] sadd(input logic signed [WORD_BITS-1:0] x,
		input logic signed [WORD_BITS-1:0] y);
		logic signed [WORD_BITS:0] t;
		t = (WORD_BITS+1)'(x) + (WORD_BITS+1)'(y);
		if (t > (WORD_BITS+1)'(WMax)) return {1'b1, WMax};
		if (t < (WORD_BITS+1)'(WMin)) return {1'b1, WMin};
		return {1'b0, t[WORD_BITS-1:0]};
	endfunction
	function automatic logic [WORD_BITS:0] ssub(input logic signed [WORD_BITS-1:0] x,
		input logic signed [WORD_BITS-1:0] y);
		logic signed [WORD_BITS:0] t;
		t = (WORD_BITS+1)'(x) - (WORD_BITS+1)'(y);
		if (t > (WORD_BITS+1)'(WMax)) return {1'b1, WMax};
		if (t < (WORD_BITS+1)'(WMin)) return {1'b1, WMin};
		return {1'b0, t[WORD_BITS-1:0]};
	endfunction

	logic [WORD_BITS:0] add_r, sub_r;
	logic signed [WORD_BITS-1:0] add_a, add_b, sub_a, sub_b;

	always_comb begin
		ma = drf_q;
		mb = dt_q;
		unique case (cmd.op)
			OP_PRED_OO: begin ma = WORD_BITS'(offset_var_rate); mb = dt_q; end
			OP_PRED_DD: begin ma = WORD_BITS'(drift_var_rate); mb = dt_q; end
			OP_UPD_OFF: begin ma = k1_q; mb = innov_q; end
			OP_UPD_DRIFT: begin ma = k2_q; mb = innov_q; end
			OP_UPD_OO: begin ma = oo_q; mb = k1_q; end
			OP_UPD_OD: begin ma = od_q; mb = k1_q; end
			OP_UPD_DO: begin ma = k2_q; mb = oo_q; end
			OP_UPD_DD: begin ma = k2_q; mb = od_q; end
			default: begin ma = drf_q; mb = dt_q; end
		endcase
	end
	// k1 holds 1 - k1 after the om step
	assign da = (cmd.op == OP_DIV_K2) ? od_q : oo_q;
	assign mstart = !status.mul_done && cmd.op != OP_NONE && cmd.op != OP_LOAD &&
		cmd.op != OP_UPD_PRE && cmd.op != OP_DIV_K1 && cmd.op != OP_DIV_K2 &&
		cmd.op != OP_UPD_OM && !mbusy_q;
	assign dstart = (cmd.op == OP_DIV_K1 || cmd.op == OP_DIV_K2) && !dbusy_q && !ddone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
		end else begin
			if (mstart) mbusy_q <= 1'b1;
			else if (mdone) mbusy_q <= 1'b0;
			if (dstart) dbusy_q <= 1'b1;
			else if (ddone) dbusy_q <= 1'b0;
		end
	end

	cokf_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.done(mdone), .p(mp), .sat(msat)
	);
	cokf_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .a(da), .d(s_q),
		.done(ddone), .q(dq), .sat(dsat)
	);

	// adder operands
	always_comb begin
		add_a = off_q;
		add_b = mp;
		sub_a = do_q;
		sub_b = mp;
		unique case (cmd.op)
			OP_PRED_OO: add_a = oo_q;
			OP_PRED_DD: add_a = dd_q;
			OP_UPD_DRIFT: add_a = drf_q;
			OP_UPD_PRE: begin add_a = oo_q; add_b = r_q; sub_a = z_q; sub_b = off_q; end
			OP_UPD_OM: begin sub_a = One; sub_b = k1_q; end
			OP_UPD_DD: sub_a = dd_q;
			default: ;
		endcase
	end
	assign add_r = sadd(add_a, add_b);
	assign sub_r = ssub(sub_a, sub_b);

	// filter state; input clip flags only count for the fields the mode uses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			drf_q <= '0;
			oo_q <= One;
			od_q <= '0;
			do_q <= '0;
			dd_q <= One;
			sat_q <= 1'b0;
			sok_q <= 1'b0;
		end else if (cmd.clr_sat) begin
			sat_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_PRED_OFF: if (mdone) begin off_q <= add_r[WORD_BITS-1:0];
					sat_q <= sat_q | clipu_s(time_step) | msat | add_r[WORD_BITS]; end
				OP_PRED_OO: if (mdone) begin oo_q <= add_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | add_r[WORD_BITS]; end
				OP_PRED_DD: if (mdone) begin dd_q <= add_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | add_r[WORD_BITS]; end
				OP_UPD_PRE: begin
					sat_q <= sat_q | clips_s(meas_offset) | clipu_s(meas_variance) |
						add_r[WORD_BITS] | sub_r[WORD_BITS];
					sok_q <= signed'(add_r[WORD_BITS-1:0]) > Eps;
				end
				OP_DIV_K1: if (ddone) sat_q <= sat_q | dsat;
				OP_DIV_K2: if (ddone) sat_q <= sat_q | dsat;
				OP_UPD_OFF: if (mdone) begin off_q <= add_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | add_r[WORD_BITS]; end
				OP_UPD_DRIFT: if (mdone) begin drf_q <= add_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | add_r[WORD_BITS]; end
				OP_UPD_OM: sat_q <= sat_q | sub_r[WORD_BITS];
				OP_UPD_OO: if (mdone) begin oo_q <= mp; sat_q <= sat_q | msat; end
				OP_UPD_OD: if (mdone) begin od_q <= mp; sat_q <= sat_q | msat; end
				OP_UPD_DO: if (mdone) begin do_q <= sub_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | sub_r[WORD_BITS]; end
				OP_UPD_DD: if (mdone) begin dd_q <= sub_r[WORD_BITS-1:0];
					sat_q <= sat_q | msat | sub_r[WORD_BITS]; end
				default: ;
			endcase
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				dt_q <= clipu(time_step);
				z_q <= clips(meas_offset);
				r_q <= clipu(meas_variance);
			end
			OP_UPD_PRE: begin
				innov_q <= sub_r[WORD_BITS-1:0];
				s_q <= add_r[WORD_BITS-1:0];
			end
			OP_DIV_K1: if (ddone) k1_q <= dq;
			OP_DIV_K2: if (ddone) k2_q <= dq;
			OP_UPD_OM: k1_q <= sub_r[WORD_BITS-1:0];
			default: ;
		endcase
	end

	// output register, frees the filter state for the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_off_q <= '0;
			res_drf_q <= '0;
			res_oo_q <= '0;
			res_sat_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_off_q <= off_q;
			res_drf_q <= drf_q;
			res_oo_q <= oo_q;
			res_sat_q <= sat_q;
		end
	end

	assign status.mul_done = mdone;
	assign status.div_done = ddone;
	assign status.s_ok = sok_q;
	assign offset_estimate = res_off_q;
	assign drift_estimate = res_drf_q;
	assign offset_variance = res_oo_q;
	assign saturated = res_sat_q;
endmodule

// ----- rtl/cokf_ctrl.sv -----
// cokf_ctrl: sequencer that steps the datapath through predict or update
// depends on cokf_pkg
module cokf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_go,
	input  logic                in_mode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                gain_applied,
	output cokf_pkg::cmd_t      cmd,
	input  cokf_pkg::status_t   status
);
	import cokf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_P_OFF, S_P_OO, S_P_DD, S_U_PRE, S_U_CHK, S_K1, S_K2,
		S_U_OFF, S_U_DRF, S_U_OM, S_U_OO, S_U_OD, S_U_DO, S_U_DD
	} state_t;

	state_t state_q;
	logic   mode_q, ovalid_q, gain_q, pend_q, pgain_q;
	logic   load_out;

	// a finished result moves to the output register once that register is free
	assign load_out = pend_q && (!ovalid_q || out_ready);

	// input is taken once the previous result has moved to the output register
	assign in_ready = (state_q == S_IDLE) && !pend_q;

	always_comb begin
		cmd.clr_sat = (state_q == S_LOAD);
		cmd.load_out = load_out;
		unique case (state_q)
			S_LOAD: cmd.op = OP_LOAD;
			S_P_OFF: cmd.op = OP_PRED_OFF;
			S_P_OO: cmd.op = OP_PRED_OO;
			S_P_DD: cmd.op = OP_PRED_DD;
			S_U_PRE: cmd.op = OP_UPD_PRE;
			S_K1: cmd.op = OP_DIV_K1;
			S_K2: cmd.op = OP_DIV_K2;
			S_U_OFF: cmd.op = OP_UPD_OFF;
			S_U_DRF: cmd.op = OP_UPD_DRIFT;
			S_U_OM: cmd.op = OP_UPD_OM;
			S_U_OO: cmd.op = OP_UPD_OO;
			S_U_OD: cmd.op = OP_UPD_OD;
			S_U_DO: cmd.op = OP_UPD_DO;
			S_U_DD: cmd.op = OP_UPD_DD;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 1'b0;
			ovalid_q <= 1'b0;
			gain_q <= 1'b0;
			pend_q <= 1'b0;
			pgain_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
				gain_q <= pgain_q;
				pend_q <= 1'b0;
			end else if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_go) begin mode_q <= in_mode; state_q <= S_LOAD; end
				S_LOAD: state_q <= (mode_q == ModeUpdate) ? S_U_PRE : S_P_OFF;
				S_P_OFF: if (status.mul_done) state_q <= S_P_OO;
				S_P_OO: if (status.mul_done) state_q <= S_P_DD;
				S_P_DD: if (status.mul_done) begin
					pgain_q <= 1'b0; pend_q <= 1'b1; state_q <= S_IDLE; end
				S_U_PRE: state_q <= S_U_CHK;
				S_U_CHK: if (status.s_ok) state_q <= S_K1;
					else begin pgain_q <= 1'b0; pend_q <= 1'b1; state_q <= S_IDLE; end
				S_K1: if (status.div_done) state_q <= S_K2;
				S_K2: if (status.div_done) state_q <= S_U_OFF;
				S_U_OFF: if (status.mul_done) state_q <= S_U_DRF;
				S_U_DRF: if (status.mul_done) state_q <= S_U_OM;
				S_U_OM: state_q <= S_U_OO;
				S_U_OO: if (status.mul_done) state_q <= S_U_OD;
				S_U_OD: if (status.mul_done) state_q <= S_U_DO;
				S_U_DO: if (status.mul_done) state_q <= S_U_DD;
				S_U_DD: if (status.mul_done) begin
					pgain_q <= 1'b1; pend_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign gain_applied = gain_q;
endmodule

// ----- rtl/clock_offset_kalman_filter_top.sv -----
// clock offset kalman filter: tracks clock offset and drift with a 2x2 covariance
// predict runs three multiplies, update runs two divides plus six multiplies, and a skipped
// update runs neither; one word is in process at a time, and input waits until the sequencer
// is idle and the previous result has entered the output reg
// reset: asynchronous, offset 0, drift 0, identity covariance, default rates, output empty
// depends on cokf_pkg, cokf_ctrl, cokf_datapath, cokf_mul, cokf_div
module clock_offset_kalman_filter_top #(
	parameter int FRAC_BITS = cokf_pkg::FracBits,
	parameter int WORD_BITS = cokf_pkg::WordBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mode
	input  logic         s_axis_tuser,
	// time_step[62:0], meas_offset[126:63], meas_variance[189:127], zero pad
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// gain_applied, saturated
	output logic [1:0]   m_axis_tuser,
	// offset_estimate[63:0], drift_estimate[127:64], offset_variance[191:128]
	output logic [191:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [cokf_pkg::RateBits-1:0] cfg_data
);
	import cokf_pkg::*;

	logic [RateBits-1:0] ovr_q, dvr_q;
	cmd_t    cmd;
	status_t status;
	logic signed [WORD_BITS-1:0] oe, de, ov;
	logic gain, sat;

	assign cfg_ready = 1'b1;
	// rate registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_q <= OffsetRateReset;
			dvr_q <= DriftRateReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgOffsetRate: ovr_q <= cfg_data;
				CfgDriftRate: dvr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cokf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_go(s_axis_tvalid && s_axis_tready), .in_mode(s_axis_tuser),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.gain_applied(gain), .cmd(cmd), .status(status)
	);

	// input fields are held in the datapath load step from a captured copy
	logic [191:0] din_q;
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) din_q <= s_axis_tdata;
	end

	cokf_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.time_step(din_q[62:0]), .meas_offset(din_q[126:63]),
		.meas_variance(din_q[189:127]),
		.offset_var_rate(ovr_q), .drift_var_rate(dvr_q),
		.offset_estimate(oe), .drift_estimate(de), .offset_variance(ov),
		.saturated(sat)
	);

	assign m_axis_tdata = {64'(ov), 64'(de), 64'(oe)};
	assign m_axis_tuser = {sat, gain};
endmodule

// ----- verif/cokf_checker.sv -----
// cokf_checker: watches the stream and config channels of the clock offset kalman filter,
// predicts each result word from its own filter state and compares field by field
// depends on cokf_pkg
`timescale 1ns / 100ps

module cokf_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic         s_axis_tuser,
	input  logic [191:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [1:0]   m_axis_tuser,
	input  logic [191:0] m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [cokf_pkg::RateBits-1:0] cfg_data,
	output int           errors,
	output int           pending
);
	import cokf_pkg::*;

	localparam logic signed [63:0] One = 64'sd1 <<< FracBits;
	localparam logic signed [63:0] WMax = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] WMin = {1'b1, {63{1'b0}}};
	localparam logic [63:0] Eps = (EpsQ64 + (64'd1 << (63 - FracBits))) >> (64 - FracBits);

	typedef struct {
		logic signed [63:0] offset;
		logic signed [63:0] drift;
		logic signed [63:0] cov_oo;
		logic               gain;
		logic               sat;
	} filter_word_t;

	filter_word_t expected_words[$];

	// filter state mirror
	logic signed [63:0] est_offset, est_drift, p_oo, p_od, p_do, p_dd;
	logic [RateBits-1:0] oo_rate, dd_rate;
	logic clipped;

	assign pending = expected_words.size();

	function automatic logic signed [63:0] clip65(input logic signed [64:0] v);
		if (v > $signed({WMax[63], WMax})) begin
			clipped = 1'b1;
			return WMax;
		end
		if (v < $signed({WMin[63], WMin})) begin
			clipped = 1'b1;
			return WMin;
		end
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a, b);
		return clip65({a[63], a} + {b[63], b});
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a, b);
		return clip65({a[63], a} - {b[63], b});
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic signed [63:0] signed_from_mag(input logic neg, input logic [127:0] v);
		logic [127:0] lim;
		lim = {65'd0, {63{1'b1}}} + 128'(neg);
		if (v > lim) begin
			clipped = 1'b1;
			return neg ? WMin : WMax;
		end
		return neg ? (~v[63:0] + 64'd1) : v[63:0];
	endfunction

	// rounded fixed point product, half away from zero
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a, b);
		logic [127:0] p;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		p = (p + (128'd1 << (FracBits - 1))) >> FracBits;
		return signed_from_mag(a[63] ^ b[63], p);
	endfunction

	// rounded fixed point quotient, d positive
	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a, d);
		logic [127:0] num;
		num = ({64'd0, magnitude(a)} << FracBits) + {65'd0, d[63:1]};
		return signed_from_mag(a[63], num / {64'd0, d});
	endfunction

	function automatic filter_word_t advance_filter(input logic mode, input logic [191:0] data);
		filter_word_t w;
		logic signed [63:0] dt, z, r, innov, s, k1, k2, om;
		clipped = 1'b0;
		w.gain = 1'b0;
		dt = {1'b0, data[62:0]};
		z = data[126:63];
		r = {1'b0, data[189:127]};
		if (mode != ModeUpdate) begin
			est_offset = sat_add(est_offset, fx_mul(est_drift, dt));
			p_oo = sat_add(p_oo, fx_mul({23'd0, oo_rate}, dt));
			p_dd = sat_add(p_dd, fx_mul({23'd0, dd_rate}, dt));
		end else begin
			innov = sat_sub(z, est_offset);
			s = sat_add(p_oo, r);
			if (s > $signed(Eps)) begin
				k1 = fx_div(p_oo, s);
				k2 = fx_div(p_od, s);
				est_offset = sat_add(est_offset, fx_mul(k1, innov));
				est_drift = sat_add(est_drift, fx_mul(k2, innov));
				om = sat_sub(One, k1);
				p_oo = fx_mul(p_oo, om);
				p_od = fx_mul(p_od, om);
				p_do = sat_sub(p_do, fx_mul(k2, p_oo));
				p_dd = sat_sub(p_dd, fx_mul(k2, p_od));
				w.gain = 1'b1;
			end
		end
		w.offset = est_offset;
		w.drift = est_drift;
		w.cov_oo = p_oo;
		w.sat = clipped;
		return w;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got, want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// predict on accepted input words, compare accepted result words
	always @(posedge clk or negedge arst_n) begin
		filter_word_t w;
		if (!arst_n) begin
			est_offset = '0;
			est_drift = '0;
			p_oo = One;
			p_od = '0;
			p_do = '0;
			p_dd = One;
			oo_rate = OffsetRateReset;
			dd_rate = DriftRateReset;
			expected_words.delete();
			errors = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
				end else begin
					w = expected_words.pop_front();
					if (m_axis_tdata[63:0] !== w.offset)
						report_mismatch("offset_estimate", m_axis_tdata[63:0], w.offset);
					if (m_axis_tdata[127:64] !== w.drift)
						report_mismatch("drift_estimate", m_axis_tdata[127:64], w.drift);
					if (m_axis_tdata[191:128] !== w.cov_oo)
						report_mismatch("offset_variance", m_axis_tdata[191:128], w.cov_oo);
					if (m_axis_tuser[0] !== w.gain)
						report_mismatch("gain_applied", 64'(m_axis_tuser[0]), 64'(w.gain));
					if (m_axis_tuser[1] !== w.sat)
						report_mismatch("saturated", 64'(m_axis_tuser[1]), 64'(w.sat));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_words.insert(expected_words.size(),
					advance_filter(s_axis_tuser, s_axis_tdata));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgOffsetRate)
					oo_rate = cfg_data;
				else if (cfg_index == CfgDriftRate)
					dd_rate = cfg_data;
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
// testbench: drives directed and random predict/update words and rate writes into the
// clock offset kalman filter, with random stalls on both sides and one long output hold
// depends on cokf_pkg, clock_offset_kalman_filter_top, cokf_checker
`timescale 1ns / 100ps

module testbench;
	import cokf_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 400;
	localparam logic [RateBits-1:0] RateTop = 41'd1 << 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic         s_axis_tuser = 1'b0;
	logic [191:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [1:0]   m_axis_tuser;
	logic [191:0] m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = 1'b0;
	logic [RateBits-1:0] cfg_data = '0;
	int           errors;
	int           pending;
	int           cycles = 0;
	logic         hold_request = 1'b0;

	clock_offset_kalman_filter_top uut (.*);

	cokf_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// offer one word, keep valid high while it waits
	task automatic send_word(input logic mode, input logic [62:0] ts,
			input logic [63:0] mo, input logic [62:0] mv);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {2'b0, mv, mo, ts};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_rate(input logic idx, input logic [RateBits-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_word();
		logic [62:0] ts;
		logic [63:0] mo;
		logic [62:0] mv;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 8) begin
			// realistic magnitudes: seconds, microsecond offsets
			ts = 63'($urandom_range(0, 32'h7fff_ffff)) << $urandom_range(0, 12);
			mo = {{24{1'b0}}, $urandom(), 8'($urandom_range(0, 255))};
			if ($urandom_range(0, 1)) mo = -mo;
			mv = 63'($urandom_range(0, 32'hffff_ffff)) << $urandom_range(0, 10);
		end else begin
			ts = 63'(rand64());
			mo = rand64();
			mv = 63'(rand64());
		end
		send_word($urandom_range(0, 1) ? ModeUpdate : ModePredict, ts, mo, mv);
	endtask

	// receiver side: random stalls plus one long hold on request
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (500) @(posedge clk);
			end
			gap = random_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default rates, extremes, zero step, skipped gains
		send_word(ModePredict, '0, '0, '0);
		send_word(ModePredict, 63'd1 << 40, '0, '0);
		send_word(ModeUpdate, '0, 64'd1 << 30, '0);
		send_word(ModeUpdate, '0, 64'd5, '0);
		send_word(ModeUpdate, '0, 64'd5, 63'd110);
		send_word(ModeUpdate, '0, 64'd5, 63'd111);
		send_word(ModePredict, {63{1'b1}}, '0, '0);
		send_word(ModeUpdate, '0, {1'b1, 63'd0}, '0);
		send_word(ModeUpdate, '0, {1'b0, {63{1'b1}}}, {63{1'b1}});
		send_word(ModePredict, {63{1'b1}}, '0, '0);
		send_word(ModeUpdate, '0, {1'b1, 63'd0}, 63'd1 << 40);
		send_word(ModeUpdate, '0, {64{1'b1}}, 63'd0);
		send_word(ModePredict, 63'd3 << 40, '0, '0);
		drain();

		// rates at extremes
		write_rate(CfgOffsetRate, '0);
		write_rate(CfgDriftRate, RateTop);
		send_word(ModePredict, 63'd1 << 40, '0, '0);
		send_word(ModePredict, {63{1'b1}}, '0, '0);
		send_word(ModeUpdate, '0, 64'd77, 63'd1);
		drain();
		write_rate(CfgOffsetRate, RateTop - 1);
		write_rate(CfgDriftRate, '0);
		send_word(ModePredict, 63'd1 << 41, '0, '0);
		send_word(ModeUpdate, '0, -64'sd1000, 63'd1 << 38);
		drain();

		// random phases, each with its own rate setting
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_rate(CfgOffsetRate, OffsetRateReset);
					write_rate(CfgDriftRate, DriftRateReset);
				end
				1: begin
					write_rate(CfgOffsetRate, RateTop);
					write_rate(CfgDriftRate, RateTop);
				end
				default: begin
					write_rate(CfgOffsetRate, RateBits'($urandom_range(0, 32'hffff_ffff)) << 8);
					write_rate(CfgDriftRate, RateBits'($urandom_range(0, 32'hffff_ffff)) << 4);
				end
			endcase
			for (int i = 0; i < 150; i++) begin
				if (phase == 1 && i == 40) hold_request = 1'b1;
				random_word();
			end
			drain();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
